[rtl/gsp_pkg.sv]
// shared types and constants for the gsm septet pack/unpack block
// no dependencies; used by every module under rtl
package gsp_pkg;

  localparam logic [7:0] SEPTET_MASK = 8'h7f;
  localparam logic [2:0] GROUP_BYTES = 3'd7;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_item;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_t;

  // one classified item: one or two result bytes
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } entry_t;

endpackage

[rtl/gsp_front.sv]
// front end: direction register, group state and per-item classification
// depends on gsp_pkg
module gsp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data,
  input  logic           accept,
  input  gsp_pkg::in_t   item,
  output logic           wr,
  output gsp_pkg::entry_t entry
);
  import gsp_pkg::*;

  logic       dir;
  logic [2:0] pos;
  logic [7:0] left;
  logic [2:0] pos_next;
  logic [7:0] left_next;

  logic [2:0] p;
  logic [7:0] unp_r0;
  logic [7:0] unp_left;
  logic       unp_wrap;
  logic [3:0] pk_sh;
  logic [7:0] pk_r0;
  logic [7:0] pk_left;
  logic [2:0] pk_pos;
  logic       pk_flush;
  logic [2:0] new_pos;
  logic [7:0] new_left;

  always_comb begin
    // unpack path
    p        = (pos == GROUP_BYTES) ? 3'd0 : pos;
    unp_r0   = (8'(item.in_byte << p) | left) & SEPTET_MASK;
    unp_left = item.in_byte >> (GROUP_BYTES - p);
    unp_wrap = (p == GROUP_BYTES - 3'd1);
    // pack path
    pk_sh    = 4'd8 - {1'b0, pos};
    pk_r0    = 8'(item.in_byte << pk_sh) | left;
    pk_left  = (pos == 3'd0) ? item.in_byte : (item.in_byte >> pos);
    pk_pos   = pos + 3'd1;
    pk_flush = item.last_item && (pk_pos != 3'd0);

    entry.last = item.last_item;
    if (!dir) begin
      entry.two = unp_wrap;
      entry.b0  = unp_r0;
      entry.b1  = unp_left;
      wr        = accept;
      new_pos   = unp_wrap ? 3'd0 : p + 3'd1;
      new_left  = unp_wrap ? 8'd0 : unp_left;
    end else begin
      if (pos == 3'd0) begin
        // first of a group: stored, sent only as a flush
        entry.two = 1'b0;
        entry.b0  = pk_left;
        entry.b1  = pk_left;
        wr        = accept && pk_flush;
      end else begin
        entry.two = pk_flush;
        entry.b0  = pk_r0;
        entry.b1  = pk_left;
        wr        = accept;
      end
      new_pos  = pk_pos;
      new_left = pk_left;
    end

    if (!accept) begin
      pos_next  = pos;
      left_next = left;
    end else if (item.last_item) begin
      pos_next  = 3'd0;
      left_next = 8'd0;
    end else begin
      pos_next  = new_pos;
      left_next = new_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir  <= 1'b0;
      pos  <= 3'd0;
      left <= 8'd0;
    end else if (cfg_wr_en) begin
      dir  <= cfg_wr_data;
      pos  <= 3'd0;
      left <= 8'd0;
    end else begin
      pos  <= pos_next;
      left <= left_next;
    end
  end

endmodule

[rtl/gsp_fifo.sv]
// short entry queue between front and back ends
// depends on gsp_pkg
module gsp_fifo #(
  parameter int unsigned DEPTH = gsp_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  gsp_pkg::entry_t wr_data,
  input  logic            rd,
  output gsp_pkg::entry_t rd_data,
  output logic            full,
  output logic            nonempty
);
  import gsp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] v);
    return (v == PTR_W'(DEPTH - 1)) ? '0 : v + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= bump(wptr);
      end
      if (rd) begin
        rptr <= bump(rptr);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/gsp_back.sv]
// back end: expands queued entries into single results on the output port
// depends on gsp_pkg
module gsp_back (
  input  logic            clk,
  input  logic            rst,
  input  gsp_pkg::entry_t head,
  input  logic            head_valid,
  output logic            head_rd,
  input  logic            pop,
  output logic            empty,
  output gsp_pkg::out_t   result
);
  import gsp_pkg::*;

  entry_t cur;
  logic   cur_valid;
  logic   phase;
  logic   final_res;
  logic   done;

  assign final_res       = phase || !cur.two;
  assign done            = pop && cur_valid && final_res;
  assign head_rd         = head_valid && (!cur_valid || done);
  assign empty           = !cur_valid;
  assign result.out_byte = phase ? cur.b1 : cur.b0;
  assign result.last_out = cur.last && final_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (!cur_valid || done) begin
      cur_valid <= head_valid;
      phase     <= 1'b0;
    end else if (pop) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_rd) begin
      cur <= head;
    end
  end

endmodule

[rtl/gsm_septet_pack_unpack_top.sv]
// top level of the gsm 7-bit septet pack/unpack block
// depends on gsp_pkg, gsp_front, gsp_fifo, gsp_back
//
// usage
//   input queue: drive item and push; a transfer happens at a clock edge with
//   push high and full low. item.last_item marks the final byte of a message.
//   result queue: while empty is low the oldest result sits on result; a
//   transfer happens at a clock edge with pop high and empty low.
//   result.last_out marks the final result of a message.
//   cfg_wr_en/cfg_wr_data write the direction bit (0 unpack, 1 pack) and
//   abandon any message in progress; write only while the block is idle.
// timing
//   one input transfer per cycle while full is low. an item's first result
//   becomes visible after the queue write and then the output register load.
//   the output port gives one result per cycle while pop is high, so items
//   that yield two results (seventh byte when unpacking, flush when packing)
//   take two output transfers; the entry queue absorbs the difference.
// reset
//   rst (synchronous) sets unpack mode, clears group state and empties
//   both the entry queue and the output register.
// stall
//   when pop stays low the output register holds; the queue fills and full
//   rises once FIFO_DEPTH entries wait, stopping input transfers.
module gsm_septet_pack_unpack_top #(
  parameter int unsigned FIFO_DEPTH = gsp_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          push,
  output logic          full,
  input  gsp_pkg::in_t  item,
  input  logic          pop,
  output logic          empty,
  output gsp_pkg::out_t result
);
  import gsp_pkg::*;

  logic   accept;
  logic   fifo_wr;
  entry_t fifo_in;
  entry_t fifo_head;
  logic   fifo_rd;
  logic   fifo_full;
  logic   fifo_nonempty;

  // input transfer
  assign accept = push && !fifo_full;
  assign full   = fifo_full;

  // classify and update group state
  gsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (item),
    .wr          (fifo_wr),
    .entry       (fifo_in)
  );

  // decoupling queue
  gsp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (fifo_wr),
    .wr_data  (fifo_in),
    .rd       (fifo_rd),
    .rd_data  (fifo_head),
    .full     (fifo_full),
    .nonempty (fifo_nonempty)
  );

  // emit results one per cycle while pop is high
  gsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (fifo_head),
    .head_valid (fifo_nonempty),
    .head_rd    (fifo_rd),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  // queue is never written while full
  assert property (@(posedge clk) disable iff (rst) !(fifo_wr && fifo_full))
    else $error("entry queue written while full");

  // a message end always yields at least one result
  assert property (@(posedge clk) disable iff (rst)
    (accept && item.last_item) |-> fifo_wr)
    else $error("last item produced no entry");

  // reset leaves no result on the port
  assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

endmodule
